// ----- design/wdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdr_pkg: shared types and constants of the wheel duty sequencer
// Item kinds, wheel state record, result word and configuration set.
// ----------------------------------------------------------------------------
package wdr_pkg;

  // Sizing
  localparam int DEFAULT_WHEELS = 4;
  localparam int MAX_RESULTS    = 4;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CMDQ_DEPTH     = 2;
  localparam int OUTQ_DEPTH     = 2;

  // Input mode codes
  localparam logic [1:0] MODE_GUARD = 2'd0;
  localparam logic [1:0] MODE_QUICK = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SLIP_DUTY  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MID_DUTY   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DUTY   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SLIP_WAIT  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JUMP_WAIT  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_IVL   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_QUICK_WAIT = 3'd6;

  // Configuration reset values
  localparam logic [7:0]  RST_SLIP_DUTY  = 8'd0;
  localparam logic [7:0]  RST_MID_DUTY   = 8'd0;
  localparam logic [7:0]  RST_MAX_DUTY   = 8'd255;
  localparam logic [15:0] RST_SLIP_WAIT  = 16'd0;
  localparam logic [15:0] RST_JUMP_WAIT  = 16'd0;
  localparam logic [15:0] RST_RAMP_IVL   = 16'd50;
  localparam logic [15:0] RST_QUICK_WAIT = 16'd50;

  // Classified item kind
  typedef enum logic [1:0] {
    KIND_GUARD = 2'd0,
    KIND_QUICK = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } item_kind_t;

  // Wheel sequence phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_RAMP   = 2'd2
  } phase_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [1:0]  wheel;
    logic [7:0]  target;
  } cmd_item_t;

  typedef struct packed {
    logic        last;
    logic        done;
    logic [7:0]  duty;
    logic [1:0]  wheel;
  } res_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic [7:0]  goal;
    phase_t      phase;
    logic [15:0] wait_cnt;
  } wheel_st_t;

  typedef struct packed {
    logic [7:0]  slip_lvl;
    logic [7:0]  mid_lvl;
    logic [7:0]  ceil_lvl;
    logic [15:0] slip_wait;
    logic [15:0] jump_wait;
    logic [15:0] ramp_ivl;
    logic [15:0] quick_wait;
  } cfg_t;

  // A zero wait counts as one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

endpackage

// ----- design/wheel_duty_ramp_slip_guard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_duty_ramp_slip_guard: per-wheel PWM duty sequencer with slip guard
// A command word passes through the command queue and the output queue on its way out.
// One drive command per cycle while the output queue has room; for a tick the sequencer
// takes it in, visits one wheel per cycle while no result is held up, and releases the last word.
// Reset: synchronous, active low; clears the queues, all wheel state and
// restores the register defaults.
// ----------------------------------------------------------------------------
module wheel_duty_ramp_slip_guard #(
  parameter int WHEELS = wdr_pkg::DEFAULT_WHEELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // wheel[1:0], target[9:2], zero pad
  input  logic [1:0]                     in_tuser,   // mode[1:0]
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // wheel_out[1:0], duty_out[9:2],
                                                     // sequence_done[10], zero pad
  output logic                           out_tlast,
  // Register write port
  input  logic                           cfg_we,
  input  logic [wdr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import wdr_pkg::*;

  cfg_t      cfg_r;
  cmd_item_t item;
  logic      item_valid;
  logic      item_pop;
  res_t      res;
  logic      res_push;
  logic      res_full;
  res_t      out_head;
  logic      out_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slip_lvl   <= RST_SLIP_DUTY;
      cfg_r.mid_lvl    <= RST_MID_DUTY;
      cfg_r.ceil_lvl   <= RST_MAX_DUTY;
      cfg_r.slip_wait  <= RST_SLIP_WAIT;
      cfg_r.jump_wait  <= RST_JUMP_WAIT;
      cfg_r.ramp_ivl   <= RST_RAMP_IVL;
      cfg_r.quick_wait <= RST_QUICK_WAIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SLIP_DUTY:  cfg_r.slip_lvl   <= cfg_wdata[7:0];
        REG_MID_DUTY:   cfg_r.mid_lvl    <= cfg_wdata[7:0];
        REG_MAX_DUTY:   cfg_r.ceil_lvl   <= cfg_wdata[7:0];
        REG_SLIP_WAIT:  cfg_r.slip_wait  <= cfg_wdata;
        REG_JUMP_WAIT:  cfg_r.jump_wait  <= cfg_wdata;
        REG_RAMP_IVL:   cfg_r.ramp_ivl   <= cfg_wdata;
        REG_QUICK_WAIT: cfg_r.quick_wait <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  wdr_front #(
    .WHEELS (WHEELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser),
    .in_wheel   (in_tdata[1:0]),
    .in_target  (in_tdata[9:2]),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  wdr_back #(
    .WHEELS (WHEELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // Output skid queue
  wdr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (out_tready),
    .rd_data (out_head),
    .empty   (out_empty)
  );

  assign out_tvalid = !out_empty;
  assign out_tdata  = {5'd0, out_head.done, out_head.duty, out_head.wheel};
  assign out_tlast  = out_head.last;

endmodule

// ----- design/wdr_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdr_fifo: small synchronous queue
// Flop-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module wdr_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/wdr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdr_front: input classifier and command queue
// Decodes each input word, drops those that cause nothing and queues the rest.
// ----------------------------------------------------------------------------
module wdr_front #(
  parameter int WHEELS = wdr_pkg::DEFAULT_WHEELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_wheel,
  input  logic [7:0]         in_target,
  output wdr_pkg::cmd_item_t item,
  output logic               item_valid,
  input  logic               item_pop
);

  import wdr_pkg::*;

  cmd_item_t  item_in;
  item_kind_t kind;
  logic       wheel_ok;
  logic       q_full;
  logic       q_empty;
  logic       push;

  assign wheel_ok = (int'(in_wheel) < WHEELS);

  // Classify the incoming word
  always_comb begin
    case (in_mode)
      MODE_GUARD: kind = wheel_ok ? KIND_GUARD : KIND_NONE;
      MODE_QUICK: kind = wheel_ok ? KIND_QUICK : KIND_NONE;
      MODE_TICK:  kind = KIND_TICK;
      default:    kind = KIND_NONE;
    endcase
  end

  assign item_in.kind   = kind;
  assign item_in.wheel  = in_wheel;
  assign item_in.target = in_target;

  // Drop words with a spare mode code or an out-of-range wheel
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && (kind != KIND_NONE);

  wdr_fifo #(
    .WIDTH ($bits(cmd_item_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (item_in),
    .full    (q_full),
    .rd_en   (item_pop),
    .rd_data (item),
    .empty   (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

// ----- design/wdr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdr_back: wheel duty sequencer
// Holds per-wheel state, applies commands and walks the wheels on each tick.
// ----------------------------------------------------------------------------
module wdr_back #(
  parameter int WHEELS = wdr_pkg::DEFAULT_WHEELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wdr_pkg::cfg_t      cfg,
  input  wdr_pkg::cmd_item_t item,
  input  logic               item_valid,
  output logic               item_pop,
  output wdr_pkg::res_t      res,
  output logic               res_push,
  input  logic               res_full
);

  import wdr_pkg::*;

  localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam logic [WIDX-1:0] LAST_WHEEL = WIDX'(WHEELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_FLUSH
  } state_t;

  state_t          state_r, state_nxt;
  logic [WIDX-1:0] idx_r, idx_nxt;
  logic [2:0]      n_r, n_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  res_t            pend_r, pend_nxt;
  wheel_st_t       wst_r [WHEELS];

  logic [WIDX-1:0] sel;
  wheel_st_t       cur;
  wheel_st_t       upd;
  logic            upd_en;

  assign sel = (state_r == ST_TICK) ? idx_r : WIDX'(item.wheel);
  assign cur = wst_r[sel];

  always_comb begin
    logic        slip_go;
    logic [15:0] wait_sel;
    logic        active;
    logic        produce;
    logic        step_done;
    logic [8:0]  nxt9;
    logic        stall;
    res_t        new_res;

    upd            = cur;
    upd_en         = 1'b0;
    item_pop       = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    slip_go        = 1'b0;
    wait_sel       = cfg.quick_wait;
    active         = (cur.phase == PH_SETTLE) || (cur.phase == PH_RAMP);
    produce        = 1'b0;
    step_done      = 1'b0;
    nxt9           = {1'b0, cur.duty} + 9'd1;
    stall          = 1'b0;

    // Step the current wheel as a tick would
    if (active && (cur.wait_cnt <= 16'd1) && (n_r < 3'(MAX_RESULTS))) begin
      if ((nxt9 <= {1'b0, cur.goal}) && (nxt9 <= {1'b0, cfg.ceil_lvl})) begin
        produce   = 1'b1;
        step_done = (nxt9 == {1'b0, cur.goal}) || (nxt9 == {1'b0, cfg.ceil_lvl});
      end
    end
    new_res.last  = 1'b0;
    new_res.done  = step_done;
    new_res.duty  = nxt9[7:0];
    new_res.wheel = 2'(idx_r);

    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.kind)
            KIND_GUARD, KIND_QUICK: begin
              // Apply a drive command once the output queue has room
              if (item.kind == KIND_GUARD) begin
                slip_go  = item.target > cfg.slip_lvl;
                wait_sel = (cfg.slip_lvl <= cfg.mid_lvl) ? cfg.slip_wait : cfg.jump_wait;
              end else begin
                slip_go  = (item.target > cfg.slip_lvl) && (cur.duty < cfg.slip_lvl);
                wait_sel = cfg.quick_wait;
              end
              if (!res_full) begin
                item_pop  = 1'b1;
                res_push  = 1'b1;
                upd_en    = 1'b1;
                res.last  = 1'b1;
                res.wheel = item.wheel;
                upd.goal  = item.target;
                if (slip_go) begin
                  upd.duty     = cfg.slip_lvl;
                  upd.phase    = PH_SETTLE;
                  upd.wait_cnt = at_least_one(wait_sel);
                  res.done     = 1'b0;
                  res.duty     = cfg.slip_lvl;
                end else begin
                  upd.duty     = item.target;
                  upd.phase    = PH_IDLE;
                  upd.wait_cnt = 16'd0;
                  res.done     = 1'b1;
                  res.duty     = item.target;
                end
              end
            end
            KIND_TICK: begin
              item_pop       = 1'b1;
              state_nxt      = ST_TICK;
              idx_nxt        = '0;
              n_nxt          = '0;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              item_pop = 1'b1;
            end
          endcase
        end
      end

      ST_TICK: begin
        // Hold when a waiting result cannot be pushed
        stall = produce && pend_valid_r && res_full;
        if (!stall) begin
          if (active) begin
            upd_en = 1'b1;
            if (cur.wait_cnt > 16'd1) begin
              upd.wait_cnt = cur.wait_cnt - 16'd1;
            end else if (n_r >= 3'(MAX_RESULTS)) begin
              upd.wait_cnt = 16'd1;
            end else if (!produce) begin
              upd.phase    = PH_IDLE;
              upd.wait_cnt = 16'd0;
            end else begin
              upd.duty = nxt9[7:0];
              if (step_done) begin
                upd.phase    = PH_IDLE;
                upd.wait_cnt = 16'd0;
              end else begin
                upd.phase    = PH_RAMP;
                upd.wait_cnt = at_least_one(cfg.ramp_ivl);
              end
            end
          end
          if (produce) begin
            if (pend_valid_r) begin
              res_push = 1'b1;
              res      = pend_r;
            end
            pend_nxt       = new_res;
            pend_valid_nxt = 1'b1;
            n_nxt          = n_r + 3'd1;
          end
          if (idx_r == LAST_WHEEL) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + WIDX'(1);
          end
        end
      end

      ST_FLUSH: begin
        // Release the final result of the tick marked as last
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (!res_full) begin
          res            = pend_r;
          res.last       = 1'b1;
          res_push       = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  // Wheel state: cleared at reset, at most one wheel written per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEELS; i++) begin
        wst_r[i].duty     <= 8'd0;
        wst_r[i].goal     <= 8'd0;
        wst_r[i].phase    <= PH_IDLE;
        wst_r[i].wait_cnt <= 16'd0;
      end
    end else if (upd_en) begin
      wst_r[sel] <= upd;
    end
  end

endmodule

// ----- verif/wheel_duty_ramp_slip_guard_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_duty_ramp_slip_guard_tb: self-checking bench for the wheel duty sequencer
// Streams drive commands and ticks into the block under several
// register settings, predicts every duty change from its own copy of the
// wheel state and checks each result word in order, with random gaps on
// both streams.
// ----------------------------------------------------------------------------
module wheel_duty_ramp_slip_guard_tb;
  import wdr_pkg::*;

  localparam int NW            = 4;
  localparam int SETTLE_CYCLES = 3 * (NW + 2) + 10;
  localparam int REPORT_LIMIT  = 10;

  // The one mode code the block has to drop
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] wheel;
    logic [7:0] target;
  } drive_word_t;

  typedef struct packed {
    logic [1:0] wheel;
    logic [7:0] duty;
    logic       done;
    logic       last;
  } duty_change_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  wheel_duty_ramp_slip_guard #(.WHEELS(NW)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // wheel[1:0], target[9:2], zero pad
    .in_tuser   (in_tuser),   // mode[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // wheel_out[1:0], duty_out[9:2], sequence_done[10], zero pad
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Predicted wheel state and register copy
  logic [7:0]  pred_duty [NW];
  logic [7:0]  pred_goal [NW];
  phase_t      pred_phase[NW];
  logic [15:0] pred_wait [NW];
  cfg_t        pred_cfg;

  drive_word_t  words_pending[$];
  duty_change_t duty_changes_due[$];
  duty_change_t step_batch[$];
  drive_word_t  cur_word;

  logic steady = 1'b0;
  int   mismatches       = 0;
  int   words_sent       = 0;
  int   changes_checked  = 0;
  int   settings_applied = 0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void emit_change(logic [1:0] w, logic [7:0] d, logic done);
    duty_change_t c;
    c.wheel = w;
    c.duty  = d;
    c.done  = done;
    c.last  = 1'b0;
    step_batch.push_back(c);
  endfunction

  function automatic void jump_wheel(logic [1:0] w, logic [7:0] d);
    pred_duty[w]  = d;
    pred_goal[w]  = d;
    pred_phase[w] = PH_IDLE;
    pred_wait[w]  = 16'd0;
    emit_change(w, d, 1'b1);
  endfunction

  function automatic void slip_wheel(logic [1:0] w, logic [7:0] target, logic [15:0] hold);
    pred_duty[w]  = pred_cfg.slip_lvl;
    pred_goal[w]  = target;
    pred_phase[w] = PH_SETTLE;
    pred_wait[w]  = (hold == 16'd0) ? 16'd1 : hold;
    emit_change(w, pred_cfg.slip_lvl, 1'b0);
  endfunction

  task automatic predict_duty_changes(input drive_word_t wd);
    logic [8:0]  nxt;
    logic [15:0] hold;
    step_batch = {};
    case (wd.mode)
      MODE_GUARD: begin
        if (wd.target <= pred_cfg.slip_lvl) begin
          jump_wheel(wd.wheel, wd.target);
        end else begin
          hold = (pred_cfg.slip_lvl <= pred_cfg.mid_lvl) ? pred_cfg.slip_wait
                                                         : pred_cfg.jump_wait;
          slip_wheel(wd.wheel, wd.target, hold);
        end
      end
      MODE_QUICK: begin
        if (wd.target > pred_cfg.slip_lvl && pred_duty[wd.wheel] < pred_cfg.slip_lvl)
          slip_wheel(wd.wheel, wd.target, pred_cfg.quick_wait);
        else
          jump_wheel(wd.wheel, wd.target);
      end
      MODE_TICK: begin
        for (int i = 0; i < NW; i++) begin
          // only settling or ramping wheels move; anything else counts as idle
          if (pred_phase[i] != PH_SETTLE && pred_phase[i] != PH_RAMP) continue;
          if (pred_wait[i] > 16'd1) begin
            pred_wait[i]--;
            continue;
          end
          if (step_batch.size() >= MAX_RESULTS) begin
            pred_wait[i] = 16'd1;
            continue;
          end
          nxt = {1'b0, pred_duty[i]} + 9'd1;
          if (nxt > pred_goal[i] || nxt > pred_cfg.ceil_lvl) begin
            // blocked by the goal or the ceiling: drop silently
            pred_phase[i] = PH_IDLE;
            pred_wait[i]  = 16'd0;
          end else begin
            pred_duty[i] = nxt[7:0];
            if (nxt == pred_goal[i] || nxt == pred_cfg.ceil_lvl) begin
              pred_phase[i] = PH_IDLE;
              pred_wait[i]  = 16'd0;
              emit_change(i[1:0], nxt[7:0], 1'b1);
            end else begin
              pred_phase[i] = PH_RAMP;
              pred_wait[i]  = (pred_cfg.ramp_ivl == 16'd0) ? 16'd1 : pred_cfg.ramp_ivl;
              emit_change(i[1:0], nxt[7:0], 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_batch.size() > 0) step_batch[step_batch.size() - 1].last = 1'b1;
    foreach (step_batch[k]) duty_changes_due.push_back(step_batch[k]);
  endtask

  function automatic void note_mismatch(string what, duty_change_t want, duty_change_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s: expected wheel %0d duty %0d done %0b last %0b",
               $time, what, want.wheel, want.duty, want.done, want.last);
      $display("%0t: %s: got wheel %0d duty %0d done %0b last %0b",
               $time, what, got.wheel, got.duty, got.done, got.last);
    end
    mismatches++;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_proc
    drive_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_duty_changes(cur_word);
        words_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the word until it is taken
      end else if (words_pending.size() > 0 && (steady || $urandom_range(0, 99) >= 10)) begin
        nxt = words_pending.pop_front();
        cur_word  <= nxt;
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, nxt.target, nxt.wheel};
        in_tuser  <= nxt.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch_proc
    duty_change_t want;
    duty_change_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.wheel = out_tdata[1:0];
        got.duty  = out_tdata[9:2];
        got.done  = out_tdata[10];
        got.last  = out_tlast;
        if (duty_changes_due.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = duty_changes_due.pop_front();
          changes_checked++;
          if (got !== want) note_mismatch("duty change differs", want, got);
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // ---------------------------------------------------------------- sequencing
  task automatic queue_word(input logic [1:0] mode, input logic [1:0] wheel,
                            input logic [7:0] target);
    drive_word_t wd;
    wd.mode   = mode;
    wd.wheel  = wheel;
    wd.target = target;
    words_pending.push_back(wd);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_SLIP_DUTY:  pred_cfg.slip_lvl   = val[7:0];
      REG_MID_DUTY:   pred_cfg.mid_lvl    = val[7:0];
      REG_MAX_DUTY:   pred_cfg.ceil_lvl   = val[7:0];
      REG_SLIP_WAIT:  pred_cfg.slip_wait  = val;
      REG_JUMP_WAIT:  pred_cfg.jump_wait  = val;
      REG_RAMP_IVL:   pred_cfg.ramp_ivl   = val;
      REG_QUICK_WAIT: pred_cfg.quick_wait = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] slip, input logic [7:0] mid,
                                input logic [7:0] top, input logic [15:0] slip_wait,
                                input logic [15:0] jump_wait, input logic [15:0] ramp,
                                input logic [15:0] quick);
    write_reg(REG_SLIP_DUTY,  {8'd0, slip});
    write_reg(REG_MID_DUTY,   {8'd0, mid});
    write_reg(REG_MAX_DUTY,   {8'd0, top});
    write_reg(REG_SLIP_WAIT,  slip_wait);
    write_reg(REG_JUMP_WAIT,  jump_wait);
    write_reg(REG_RAMP_IVL,   ramp);
    write_reg(REG_QUICK_WAIT, quick);
    settings_applied++;
  endtask

  // Fill with mostly ticks, targets biased to just above the slip duty
  task automatic load_random(input int count);
    int          taken;
    int          pick;
    logic [1:0]  mode;
    logic [8:0]  near;
    logic [7:0]  target;
    taken = 0;
    while (taken < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      mode = MODE_TICK;
      else if (pick < 75) mode = MODE_GUARD;
      else if (pick < 95) mode = MODE_QUICK;
      else                mode = MODE_SPARE;
      near = {1'b0, pred_cfg.slip_lvl} + 9'($urandom_range(0, 8));
      if ($urandom_range(0, 1)) target = 8'($urandom);
      else                      target = near[8] ? 8'hFF : near[7:0];
      queue_word(mode, 2'($urandom_range(0, 3)), target);
      taken++;
    end
  endtask

  // Pause the sender until every predicted change is back and the block is quiet
  task automatic wait_drained();
    do @(negedge clk);
    while (words_pending.size() != 0 || in_tvalid || duty_changes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : main_proc
    for (int i = 0; i < NW; i++) begin
      pred_duty[i]  = 8'd0;
      pred_goal[i]  = 8'd0;
      pred_phase[i] = PH_IDLE;
      pred_wait[i]  = 16'd0;
    end
    pred_cfg.slip_lvl   = RST_SLIP_DUTY;
    pred_cfg.mid_lvl    = RST_MID_DUTY;
    pred_cfg.ceil_lvl   = RST_MAX_DUTY;
    pred_cfg.slip_wait  = RST_SLIP_WAIT;
    pred_cfg.jump_wait  = RST_JUMP_WAIT;
    pred_cfg.ramp_ivl   = RST_RAMP_IVL;
    pred_cfg.quick_wait = RST_QUICK_WAIT;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: direct jumps, a slip step, a replaced sequence, a dropped mode
    queue_word(MODE_GUARD, 2'd0, 8'd0);
    queue_word(MODE_GUARD, 2'd1, 8'd255);
    queue_word(MODE_TICK,  2'd0, 8'd0);
    queue_word(MODE_QUICK, 2'd2, 8'd200);
    queue_word(MODE_QUICK, 2'd3, 8'd0);
    queue_word(MODE_SPARE, 2'd3, 8'd255);
    queue_word(MODE_GUARD, 2'd1, 8'd5);
    queue_word(MODE_TICK,  2'd3, 8'd255);
    wait_drained();

    // Zero waits, ceiling at the slip duty so the ramp is blocked
    apply_settings(8'd100, 8'd150, 8'd100, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_word(MODE_GUARD, 2'd0, 8'd100);
    queue_word(MODE_GUARD, 2'd0, 8'd101);
    queue_word(MODE_TICK,  2'd0, 8'd0);
    queue_word(MODE_TICK,  2'd0, 8'd0);
    queue_word(MODE_QUICK, 2'd1, 8'd150);
    queue_word(MODE_QUICK, 2'd2, 8'd150);
    queue_word(MODE_TICK,  2'd2, 8'd0);
    queue_word(MODE_GUARD, 2'd3, 8'd255);
    queue_word(MODE_TICK,  2'd1, 8'd0);
    queue_word(MODE_TICK,  2'd1, 8'd0);
    wait_drained();

    // Ramps that stop at the ceiling
    apply_settings(8'd100, 8'd150, 8'd110, 16'd2, 16'd3, 16'd0, 16'd1);
    load_random(75);
    wait_drained();

    // Jump wait chosen, full ceiling, no idling on either stream
    steady = 1'b1;
    apply_settings(8'd200, 8'd50, 8'd255, 16'd5, 16'd0, 16'd1, 16'd0);
    load_random(75);
    wait_drained();
    steady = 1'b0;

    // Upper extremes: every drive command is a direct jump
    apply_settings(8'd255, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_random(60);
    wait_drained();

    // Lower extremes: every non-zero guarded target slips first
    apply_settings(8'd0, 8'd0, 8'd255, 16'd0, 16'hFFFF, 16'd2, 16'd3);
    load_random(80);
    wait_drained();

    apply_settings(8'd10, 8'd9, 8'd20, 16'd1, 16'd2, 16'd3, 16'd2);
    load_random(80);
    wait_drained();

    // Random duties with short waits
    apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
    load_random(90);
    wait_drained();

    $display("Covered %0d input words under %0d register settings beyond reset,",
             words_sent, settings_applied);
    $display("with %0d duty changes compared against the prediction.", changes_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
